FILE: sv/keyword_lexer_macros.svh
// Assertion helpers used by the formatter module (kl_back).
`ifndef KEYWORD_LEXER_MACROS_SVH
`define KEYWORD_LEXER_MACROS_SVH

// Plain check, sampled on clk, off during reset.
`define KL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication check, sampled on clk, off during reset.
`define KL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: sv/kl_pkg.sv
// ----------------------------------------------------------------------------
// kl_pkg
// Types, token codes and keyword table of the keyword lexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kl_pkg;

    localparam int unsigned MAX_NAME_CHARS_DEF = 16;
    localparam int unsigned NUMBER_BITS_DEF    = 32;
    localparam int unsigned LINE_BITS_DEF      = 16;
    localparam int unsigned QUEUE_DEPTH        = 2;
    localparam int unsigned KW_COUNT           = 21;

    // token kinds
    localparam logic [5:0] KIND_IDENT    = 6'd0;
    localparam logic [5:0] KIND_NUMBER   = 6'd1;
    localparam logic [5:0] KIND_KW_FIRST = 6'd2;
    localparam logic [5:0] KIND_ASSIGN   = 6'd23;
    localparam logic [5:0] KIND_COLON    = 6'd24;
    localparam logic [5:0] KIND_PLUS     = 6'd25;
    localparam logic [5:0] KIND_MINUS    = 6'd26;
    localparam logic [5:0] KIND_STAR     = 6'd27;
    localparam logic [5:0] KIND_NE       = 6'd28;
    localparam logic [5:0] KIND_LE       = 6'd29;
    localparam logic [5:0] KIND_LT       = 6'd30;
    localparam logic [5:0] KIND_GE       = 6'd31;
    localparam logic [5:0] KIND_GT       = 6'd32;
    localparam logic [5:0] KIND_EQ       = 6'd33;
    localparam logic [5:0] KIND_SEMI     = 6'd34;
    localparam logic [5:0] KIND_DOT      = 6'd35;
    localparam logic [5:0] KIND_COMMA    = 6'd36;
    localparam logic [5:0] KIND_RPAREN   = 6'd37;
    localparam logic [5:0] KIND_LPAREN   = 6'd38;
    localparam logic [5:0] KIND_END      = 6'd39;
    localparam logic [5:0] KIND_ERROR    = 6'd40;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN = 3'd1;
    localparam logic [2:0] ERR_STRAY   = 3'd2;
    localparam logic [2:0] ERR_OPEN    = 3'd3;
    localparam logic [2:0] ERR_BANG    = 3'd4;

    // character codes
    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_SPACE      = 8'd32;
    localparam logic [7:0] CH_BANG       = 8'd33;
    localparam logic [7:0] CH_LPAREN     = 8'd40;
    localparam logic [7:0] CH_RPAREN     = 8'd41;
    localparam logic [7:0] CH_STAR       = 8'd42;
    localparam logic [7:0] CH_PLUS       = 8'd43;
    localparam logic [7:0] CH_COMMA      = 8'd44;
    localparam logic [7:0] CH_MINUS      = 8'd45;
    localparam logic [7:0] CH_DOT        = 8'd46;
    localparam logic [7:0] CH_ZERO       = 8'd48;
    localparam logic [7:0] CH_NINE       = 8'd57;
    localparam logic [7:0] CH_COLON      = 8'd58;
    localparam logic [7:0] CH_SEMI       = 8'd59;
    localparam logic [7:0] CH_LESS       = 8'd60;
    localparam logic [7:0] CH_EQUAL      = 8'd61;
    localparam logic [7:0] CH_GREATER    = 8'd62;
    localparam logic [7:0] CH_UPPER_A    = 8'd65;
    localparam logic [7:0] CH_UPPER_Z    = 8'd90;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;
    localparam logic [7:0] CH_LOWER_A    = 8'd97;
    localparam logic [7:0] CH_LOWER_Z    = 8'd122;
    localparam logic [7:0] CH_LBRACE     = 8'd123;
    localparam logic [7:0] CH_RBRACE     = 8'd125;
    localparam logic [7:0] CASE_OFFSET   = 8'd32;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_NAME,
        MODE_COLON,
        MODE_LESS,
        MODE_GREATER,
        MODE_BANG,
        MODE_COMMENT,
        MODE_STOPPED
    } mode_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [63:0] text_low;
        logic [63:0] text_high;
        logic [7:0]  text_length;
        logic [31:0] number_value;
        logic        too_long;
        logic [15:0] line_number;
        logic [2:0]  error_code;
        logic        last;
    } token_t;

    // first token of a beat group, full payload
    typedef struct packed {
        logic [5:0]   kind;
        logic         is_name;
        logic [127:0] text;
        logic [7:0]   length;
        logic [31:0]  number;
        logic         too_long;
        logic [15:0]  line;
        logic [2:0]   err;
    } tok_a_t;

    // second token: never a name or a number
    typedef struct packed {
        logic [5:0]  kind;
        logic [15:0] line;
        logic [2:0]  err;
    } tok_b_t;

    typedef struct packed {
        tok_a_t a;
        tok_b_t b;
        logic   two;
    } q_entry_t;

    // string literal is right justified; put first character in the low byte
    function automatic logic [127:0] kw_rev(logic [127:0] s, logic [7:0] len);
        logic [127:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            if (8'(i) < len) begin
                r[i*8 +: 8] = s[(32'(len) - 1 - i)*8 +: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] kw_len(int unsigned k);
        case (k)
            0:       return 8'd8;
            1:       return 8'd2;
            2:       return 8'd5;
            3:       return 8'd5;
            4:       return 8'd8;
            5:       return 8'd4;
            6:       return 8'd6;
            7:       return 8'd3;
            8:       return 8'd7;
            9:       return 8'd4;
            10:      return 8'd3;
            11:      return 8'd7;
            12:      return 8'd8;
            13:      return 8'd10;
            14:      return 8'd5;
            15:      return 8'd12;
            16:      return 8'd6;
            17:      return 8'd3;
            18:      return 8'd2;
            19:      return 8'd3;
            20:      return 8'd1;
            default: return 8'd0;
        endcase
    endfunction

    function automatic logic [127:0] kw_text(int unsigned k);
        logic [127:0] s;
        case (k)
            0:       s = 128'("programa");
            1:       s = 128'("se");
            2:       s = 128'("entao");
            3:       s = 128'("senao");
            4:       s = 128'("enquanto");
            5:       s = 128'("faca");
            6:       s = 128'("inicio");
            7:       s = 128'("fim");
            8:       s = 128'("escreva");
            9:       s = 128'("leia");
            10:      s = 128'("var");
            11:      s = 128'("inteiro");
            12:      s = 128'("booleano");
            13:      s = 128'("verdadeiro");
            14:      s = 128'("falso");
            15:      s = 128'("procedimento");
            16:      s = 128'("funcao");
            17:      s = 128'("div");
            18:      s = 128'("ou");
            19:      s = 128'("nao");
            20:      s = 128'("e");
            default: s = '0;
        endcase
        return kw_rev(s, kw_len(k));
    endfunction

endpackage

FILE: sv/kl_front.sv
// ----------------------------------------------------------------------------
// kl_front
// Scanner: takes one byte a beat, tracks mode, builds names and numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kl_front #(
    parameter int unsigned MAX_NAME_CHARS = kl_pkg::MAX_NAME_CHARS_DEF,
    parameter int unsigned NUMBER_BITS    = kl_pkg::NUMBER_BITS_DEF,
    parameter int unsigned LINE_BITS      = kl_pkg::LINE_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  kl_pkg::item_t    item,
    output logic             q_push,
    output kl_pkg::q_entry_t q_data
);

    localparam int unsigned NIDX = $clog2(MAX_NAME_CHARS);

    kl_pkg::mode_t mode_reg, mode_next, start_mode;

    logic [7:0]             name_buf_reg [MAX_NAME_CHARS];
    logic [7:0]             name_count_reg, name_count_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    logic                   ovf_reg, ovf_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [LINE_BITS-1:0]   cline_reg, cline_next;

    logic [7:0] c;
    logic       eoi, is_digit, is_letter, is_alnum;

    assign c         = item.char_code;
    assign eoi       = item.end_of_input;
    assign is_digit  = c inside {[kl_pkg::CH_ZERO:kl_pkg::CH_NINE]};
    assign is_letter = c inside {[kl_pkg::CH_UPPER_A:kl_pkg::CH_UPPER_Z],
                                 [kl_pkg::CH_LOWER_A:kl_pkg::CH_LOWER_Z],
                                 kl_pkg::CH_UNDERSCORE};
    assign is_alnum  = is_letter || is_digit;

    // digit append with saturation
    logic                   dig_from_zero;
    logic [NUMBER_BITS-1:0] dig_base;
    logic [NUMBER_BITS+3:0] dig_sum;
    logic                   dig_ovf;

    assign dig_base = dig_from_zero ? '0 : acc_reg;
    assign dig_sum  = ({4'b0, dig_base} << 3) + ({4'b0, dig_base} << 1)
                    + (NUMBER_BITS+4)'(c - kl_pkg::CH_ZERO);
    assign dig_ovf  = |dig_sum[NUMBER_BITS+3:NUMBER_BITS];

    // name append
    logic       name_from_zero;
    logic [7:0] name_base, lc;

    assign name_base = name_from_zero ? 8'd0 : name_count_reg;
    assign lc = (c inside {[kl_pkg::CH_UPPER_A:kl_pkg::CH_UPPER_Z]})
              ? c + kl_pkg::CASE_OFFSET : c;

    // snapshot of the kept name text, zero past the count
    logic [127:0] snap;
    for (genvar gi = 0; gi < 16; gi++) begin : g_snap
        if (gi < MAX_NAME_CHARS) begin : g_keep
            assign snap[gi*8 +: 8] = (8'(gi) < name_count_reg) ? name_buf_reg[gi] : 8'd0;
        end else begin : g_pad
            assign snap[gi*8 +: 8] = 8'd0;
        end
    end

    logic line_inc;
    logic [LINE_BITS-1:0] line_inc_val;
    assign line_inc_val = (line_reg == '1) ? line_reg : line_reg + 1'b1;

    // mode a fresh character leads to
    always_comb
    begin
        case (c)
            kl_pkg::CH_SPACE, kl_pkg::CH_NEWLINE: start_mode = kl_pkg::MODE_IDLE;
            kl_pkg::CH_LBRACE:  start_mode = kl_pkg::MODE_COMMENT;
            kl_pkg::CH_COLON:   start_mode = kl_pkg::MODE_COLON;
            kl_pkg::CH_LESS:    start_mode = kl_pkg::MODE_LESS;
            kl_pkg::CH_GREATER: start_mode = kl_pkg::MODE_GREATER;
            kl_pkg::CH_BANG:    start_mode = kl_pkg::MODE_BANG;
            kl_pkg::CH_PLUS, kl_pkg::CH_MINUS, kl_pkg::CH_STAR, kl_pkg::CH_EQUAL,
            kl_pkg::CH_SEMI, kl_pkg::CH_DOT, kl_pkg::CH_COMMA, kl_pkg::CH_RPAREN,
            kl_pkg::CH_LPAREN:  start_mode = kl_pkg::MODE_IDLE;
            default:
            begin
                if (is_digit)       start_mode = kl_pkg::MODE_NUMBER;
                else if (is_letter) start_mode = kl_pkg::MODE_NAME;
                else                start_mode = kl_pkg::MODE_STOPPED;
            end
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        if (accept && mode_reg != kl_pkg::MODE_STOPPED) begin
            if (eoi) begin
                mode_next = kl_pkg::MODE_STOPPED;
            end else begin
                case (mode_reg)
                    kl_pkg::MODE_COMMENT:
                        if (c == kl_pkg::CH_RBRACE) mode_next = kl_pkg::MODE_IDLE;
                    kl_pkg::MODE_NUMBER:
                        mode_next = is_digit ? kl_pkg::MODE_NUMBER : start_mode;
                    kl_pkg::MODE_NAME:
                        mode_next = is_alnum ? kl_pkg::MODE_NAME : start_mode;
                    kl_pkg::MODE_COLON, kl_pkg::MODE_LESS, kl_pkg::MODE_GREATER:
                        mode_next = (c == kl_pkg::CH_EQUAL) ? kl_pkg::MODE_IDLE : start_mode;
                    kl_pkg::MODE_BANG:
                        mode_next = (c == kl_pkg::CH_EQUAL) ? kl_pkg::MODE_IDLE
                                                            : kl_pkg::MODE_STOPPED;
                    default:
                        mode_next = start_mode;
                endcase
            end
        end
    end

    // tokens and datapath
    logic       pend_v, pend_name, pend_num, run_start, st_v;
    logic [5:0] pend_kind, st_kind;
    logic [2:0] pend_err, st_err;
    logic [LINE_BITS-1:0] pend_line;
    logic       dig_en, name_en;

    always_comb
    begin
        pend_v = 1'b0; pend_name = 1'b0; pend_num = 1'b0;
        pend_kind = kl_pkg::KIND_IDENT; pend_err = kl_pkg::ERR_NONE; pend_line = line_reg;
        run_start = 1'b0; st_v = 1'b0;
        st_kind = kl_pkg::KIND_IDENT; st_err = kl_pkg::ERR_NONE;
        dig_en = 1'b0; dig_from_zero = 1'b0;
        name_en = 1'b0; name_from_zero = 1'b0;
        line_inc = 1'b0;
        cline_next = cline_reg;

        if (accept && mode_reg != kl_pkg::MODE_STOPPED) begin
            if (eoi) begin
                case (mode_reg)
                    kl_pkg::MODE_NUMBER:  begin pend_v = 1'b1; pend_num = 1'b1;
                                                pend_kind = kl_pkg::KIND_NUMBER; end
                    kl_pkg::MODE_NAME:    begin pend_v = 1'b1; pend_name = 1'b1; end
                    kl_pkg::MODE_COLON:   begin pend_v = 1'b1; pend_kind = kl_pkg::KIND_COLON; end
                    kl_pkg::MODE_LESS:    begin pend_v = 1'b1; pend_kind = kl_pkg::KIND_LT; end
                    kl_pkg::MODE_GREATER: begin pend_v = 1'b1; pend_kind = kl_pkg::KIND_GT; end
                    kl_pkg::MODE_BANG:    begin pend_v = 1'b1; pend_kind = kl_pkg::KIND_ERROR;
                                                pend_err = kl_pkg::ERR_BANG; end
                    kl_pkg::MODE_COMMENT: begin pend_v = 1'b1; pend_kind = kl_pkg::KIND_ERROR;
                                                pend_err = kl_pkg::ERR_OPEN;
                                                pend_line = cline_reg; end
                    default: ;
                endcase
                // the end token follows unless an error stopped the scan
                if (pend_kind != kl_pkg::KIND_ERROR) begin
                    st_v = 1'b1; st_kind = kl_pkg::KIND_END;
                end
            end else begin
                case (mode_reg)
                    kl_pkg::MODE_COMMENT:
                        if (c == kl_pkg::CH_NEWLINE) line_inc = 1'b1;
                    kl_pkg::MODE_NUMBER:
                        if (is_digit) dig_en = 1'b1;
                        else begin pend_v = 1'b1; pend_num = 1'b1;
                                   pend_kind = kl_pkg::KIND_NUMBER; run_start = 1'b1; end
                    kl_pkg::MODE_NAME:
                        if (is_alnum) name_en = 1'b1;
                        else begin pend_v = 1'b1; pend_name = 1'b1; run_start = 1'b1; end
                    kl_pkg::MODE_COLON, kl_pkg::MODE_LESS, kl_pkg::MODE_GREATER:
                    begin
                        pend_v = 1'b1;
                        run_start = (c != kl_pkg::CH_EQUAL);
                        case (mode_reg)
                            kl_pkg::MODE_COLON: pend_kind = run_start ? kl_pkg::KIND_COLON
                                                                      : kl_pkg::KIND_ASSIGN;
                            kl_pkg::MODE_LESS:  pend_kind = run_start ? kl_pkg::KIND_LT
                                                                      : kl_pkg::KIND_LE;
                            default:            pend_kind = run_start ? kl_pkg::KIND_GT
                                                                      : kl_pkg::KIND_GE;
                        endcase
                    end
                    kl_pkg::MODE_BANG:
                    begin
                        pend_v = 1'b1;
                        if (c == kl_pkg::CH_EQUAL) pend_kind = kl_pkg::KIND_NE;
                        else begin pend_kind = kl_pkg::KIND_ERROR; pend_err = kl_pkg::ERR_BANG; end
                    end
                    default:
                        run_start = 1'b1;
                endcase

                if (run_start) begin
                    st_v = 1'b1;
                    case (c)
                        kl_pkg::CH_SPACE:   st_v = 1'b0;
                        kl_pkg::CH_NEWLINE: begin st_v = 1'b0; line_inc = 1'b1; end
                        kl_pkg::CH_LBRACE:  begin st_v = 1'b0; cline_next = line_reg; end
                        kl_pkg::CH_RBRACE:  begin st_kind = kl_pkg::KIND_ERROR;
                                                  st_err = kl_pkg::ERR_STRAY; end
                        kl_pkg::CH_COLON, kl_pkg::CH_LESS, kl_pkg::CH_GREATER,
                        kl_pkg::CH_BANG:    st_v = 1'b0;
                        kl_pkg::CH_PLUS:    st_kind = kl_pkg::KIND_PLUS;
                        kl_pkg::CH_MINUS:   st_kind = kl_pkg::KIND_MINUS;
                        kl_pkg::CH_STAR:    st_kind = kl_pkg::KIND_STAR;
                        kl_pkg::CH_EQUAL:   st_kind = kl_pkg::KIND_EQ;
                        kl_pkg::CH_SEMI:    st_kind = kl_pkg::KIND_SEMI;
                        kl_pkg::CH_DOT:     st_kind = kl_pkg::KIND_DOT;
                        kl_pkg::CH_COMMA:   st_kind = kl_pkg::KIND_COMMA;
                        kl_pkg::CH_RPAREN:  st_kind = kl_pkg::KIND_RPAREN;
                        kl_pkg::CH_LPAREN:  st_kind = kl_pkg::KIND_LPAREN;
                        default:
                        begin
                            if (is_digit) begin
                                st_v = 1'b0; dig_en = 1'b1; dig_from_zero = 1'b1;
                            end else if (is_letter) begin
                                st_v = 1'b0; name_en = 1'b1; name_from_zero = 1'b1;
                            end else begin
                                st_kind = kl_pkg::KIND_ERROR; st_err = kl_pkg::ERR_UNKNOWN;
                            end
                        end
                    endcase
                end
            end
        end

        acc_next = acc_reg;
        ovf_next = ovf_reg;
        if (dig_en) begin
            acc_next = dig_ovf ? '1 : dig_sum[NUMBER_BITS-1:0];
            ovf_next = (dig_from_zero ? 1'b0 : ovf_reg) | dig_ovf;
        end
        name_count_next = name_count_reg;
        if (name_en) begin
            name_count_next = (name_base == 8'hFF) ? name_base : name_base + 8'd1;
        end
        line_next = line_inc ? line_inc_val : line_reg;
    end

    // queue entry: pending token first, then the fresh one
    always_comb
    begin
        q_data = '0;
        q_push = pend_v || st_v;
        q_data.two = pend_v && st_v;
        if (pend_v) begin
            q_data.a.kind    = pend_kind;
            q_data.a.is_name = pend_name;
            q_data.a.line    = 16'(pend_line);
            q_data.a.err     = pend_err;
            if (pend_name) begin
                q_data.a.text     = snap;
                q_data.a.length   = name_count_reg;
                q_data.a.too_long = name_count_reg > 8'(MAX_NAME_CHARS);
            end
            if (pend_num) begin
                q_data.a.number   = 32'(acc_reg);
                q_data.a.too_long = ovf_reg;
            end
            q_data.b.kind = st_kind;
            q_data.b.line = 16'(line_reg);
            q_data.b.err  = st_err;
        end else begin
            q_data.a.kind = st_kind;
            q_data.a.line = 16'(line_reg);
            q_data.a.err  = st_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= kl_pkg::MODE_IDLE;
            name_count_reg <= 8'd0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            line_reg       <= LINE_BITS'(1);
            cline_reg      <= '0;
        end else begin
            mode_reg       <= mode_next;
            name_count_reg <= name_count_next;
            acc_reg        <= acc_next;
            ovf_reg        <= ovf_next;
            line_reg       <= line_next;
            cline_reg      <= cline_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_en && name_base < 8'(MAX_NAME_CHARS)) begin
            name_buf_reg[name_base[NIDX-1:0]] <= lc;
        end
    end

endmodule

FILE: sv/kl_queue.sv
// ----------------------------------------------------------------------------
// kl_queue
// Short queue of token groups between scanner and formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kl_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kl_pkg::q_entry_t wr_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output kl_pkg::q_entry_t rd_data
);

    localparam int unsigned PW = $clog2(kl_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(kl_pkg::QUEUE_DEPTH + 1);

    kl_pkg::q_entry_t mem_reg [kl_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = count_reg == CW'(kl_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= (wr_ptr_reg == PW'(kl_pkg::QUEUE_DEPTH - 1))
                                    ? '0 : wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= (rd_ptr_reg == PW'(kl_pkg::QUEUE_DEPTH - 1))
                                    ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

FILE: sv/kl_back.sv
// ----------------------------------------------------------------------------
// kl_back
// Formatter: resolves keywords and hands out one token a beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keyword_lexer_macros.svh"

module kl_back #(
    parameter int unsigned MAX_NAME_CHARS = kl_pkg::MAX_NAME_CHARS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  kl_pkg::q_entry_t q_data,
    output logic             q_pop,
    input  logic             pop,
    output logic             empty,
    output kl_pkg::token_t   token
);

    logic           out_valid_reg;
    kl_pkg::token_t out_reg, out_next;
    logic           phase_reg;
    logic           advance;
    logic [5:0]     name_kind;

    assign advance = !out_valid_reg || pop;
    assign q_pop   = advance && !q_empty && (phase_reg || !q_data.two);
    assign empty   = !out_valid_reg;
    assign token   = out_reg;

    // keyword lookup; over-long names never match
    always_comb
    begin
        name_kind = kl_pkg::KIND_IDENT;
        if (q_data.a.length <= 8'(MAX_NAME_CHARS)) begin
            for (int k = kl_pkg::KW_COUNT - 1; k >= 0; k--) begin
                if (q_data.a.text == kl_pkg::kw_text(k) &&
                    q_data.a.length == kl_pkg::kw_len(k)) begin
                    name_kind = kl_pkg::KIND_KW_FIRST + 6'(k);
                end
            end
        end
    end

    always_comb
    begin
        out_next = '0;
        if (phase_reg) begin
            out_next.token_kind  = q_data.b.kind;
            out_next.line_number = q_data.b.line;
            out_next.error_code  = q_data.b.err;
            out_next.last        = 1'b1;
        end else begin
            out_next.token_kind   = q_data.a.is_name ? name_kind : q_data.a.kind;
            out_next.text_low     = q_data.a.text[63:0];
            out_next.text_high    = q_data.a.text[127:64];
            out_next.text_length  = q_data.a.length;
            out_next.number_value = q_data.a.number;
            out_next.too_long     = q_data.a.too_long;
            out_next.line_number  = q_data.a.line;
            out_next.error_code   = q_data.a.err;
            out_next.last         = !q_data.two;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= !q_empty;
            if (!q_empty) phase_reg <= !phase_reg && q_data.two;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !q_empty) out_reg <= out_next;
    end

    `KL_ASSERT_IMP(a_phase_has_entry, phase_reg, !q_empty, "second token with empty queue")
    `KL_ASSERT_IMP(a_phase_two, phase_reg, q_data.two, "second token of single group")
    `KL_ASSERT(a_not_last_pending, !(out_valid_reg && !out_reg.last && !phase_reg),
               "first of two shown without second pending")

endmodule

FILE: sv/keyword_lexer.sv
// ----------------------------------------------------------------------------
// keyword_lexer
// Byte-serial lexical analyzer with keyword matching, queue interface.
// ----------------------------------------------------------------------------
// One source byte goes in per push beat; each byte yields zero, one or two
// token beats on the result side. Throughput: a byte that makes at most one
// token is taken every cycle while the queue has room; one that makes two (a
// name, number or : < > ended by another token, or a pending token plus the
// end token) holds the formatter for both; it hands out one token per cycle
// while pop is high. A byte's first token is queued at the accepting edge,
// then registered in the formatter's output. Scanner and formatter have a
// two-group queue between them, so the scanner keeps taking bytes while the
// formatter waits on pop, until the queue is full. After an error token or
// the end token the block ignores all input until rst_n is asserted.
`timescale 1ns / 1ps

module keyword_lexer #(
    parameter int unsigned MAX_NAME_CHARS = kl_pkg::MAX_NAME_CHARS_DEF,
    parameter int unsigned NUMBER_BITS    = kl_pkg::NUMBER_BITS_DEF,
    parameter int unsigned LINE_BITS      = kl_pkg::LINE_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  kl_pkg::item_t  item,
    output logic           empty,
    input  logic           pop,
    output kl_pkg::token_t token
);

    logic             q_full, q_empty, q_push, q_pop, accept;
    kl_pkg::q_entry_t q_wr, q_rd;

    // input beat is taken whenever the queue has room for another group
    assign full   = q_full;
    assign accept = push && !q_full;

    kl_front #(
        .MAX_NAME_CHARS(MAX_NAME_CHARS),
        .NUMBER_BITS   (NUMBER_BITS),
        .LINE_BITS     (LINE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .accept(accept),
        .item  (item),
        .q_push(q_push),
        .q_data(q_wr)
    );

    kl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wr_data(q_wr),
        .pop    (q_pop),
        .full   (q_full),
        .empty  (q_empty),
        .rd_data(q_rd)
    );

    kl_back #(
        .MAX_NAME_CHARS(MAX_NAME_CHARS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .q_data (q_rd),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .token  (token)
    );

endmodule
